// ----- sv/stt_pkg.sv -----
`default_nettype none

package stt_pkg;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_ALLOC = 3'd1,
        OP_FREE  = 3'd2,
        OP_INIT  = 3'd3,
        OP_START = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_UNUSED  = 2'd0,
        ST_ALLOC   = 2'd1,
        ST_RUNNING = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_TICK,
        S_FLUSH
    } t_state;

    localparam logic KindAlloc  = 1'b0;
    localparam logic KindExpire = 1'b1;

    localparam int MaxResults = 32;
    localparam int CntW       = $clog2(MaxResults + 1);
    localparam int QueueDepth = 2;
    localparam int PtrW       = $clog2(QueueDepth);

    typedef struct packed {
        t_op         op;
        logic [4:0]  idx;
        logic [31:0] timeout;
        logic [3:0]  queue;
        logic [7:0]  payload;
    } t_cmd;

    typedef struct packed {
        logic        kind;
        logic [4:0]  slot;
        logic        ok;
        logic [3:0]  queue;
        logic [7:0]  payload;
        logic [31:0] ticks;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/software_timer_table_top.sv -----
`default_nettype none

// Channel   Dir  Transfer payload
// s_axis    in   tuser: action[2:0]; tdata: timer_index, timeout_ticks, dest_queue,
//                payload_byte
// m_axis    out  tuser: event_kind; tdata: slot, alloc_ok, out_queue, out_payload,
//                ticks_seen; tlast: last
//
// Free, set destination and start are carried out in the idle state as they are popped.
// Allocate runs through the pop, its walk over the status entries and then the load
// of the reply.
// A tick runs through the pop, one entry per cycle through the countdown memory read port
// while no result stall holds the sweep, the drain of that read pipeline, then the
// release of the marked last event.
// Reset is synchronous and marks every entry unused; no clearing pass is needed.
// A stalled result output holds the sweep once a further expiry must be passed on; a
// two-entry command queue keeps accepting until it is full.

module software_timer_table_top #(
    parameter int NUM_TIMERS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [4:0] timer_index, [36:5] timeout_ticks, [40:37] dest_queue,
    // [48:41] payload_byte, [55:49] zero
    input  wire logic [55:0] i_s_axis_tdata,
    // [2:0] action
    input  wire logic [2:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [4:0] slot, [5] alloc_ok, [9:6] out_queue, [17:10] out_payload,
    // [49:18] ticks_seen, [55:50] zero
    output logic [55:0]      o_m_axis_tdata,
    // [0] event_kind
    output logic [0:0]       o_m_axis_tuser,
    output logic             o_m_axis_tlast
);
    import stt_pkg::*;

    logic    q_full;
    logic    q_empty;
    logic    push;
    logic    pop;
    t_cmd    push_cmd;
    t_cmd    head_cmd;
    t_result result;

    stt_front #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_front (
        .i_valid   (i_s_axis_tvalid),
        .i_action  (i_s_axis_tuser),
        .i_index   (i_s_axis_tdata[4:0]),
        .i_timeout (i_s_axis_tdata[36:5]),
        .i_queue   (i_s_axis_tdata[40:37]),
        .i_payload (i_s_axis_tdata[48:41]),
        .i_q_full  (q_full),
        .o_ready   (o_s_axis_tready),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    stt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    stt_back #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_result  (result)
    );

    assign o_m_axis_tdata = {6'd0, result.ticks, result.payload, result.queue,
                             result.ok, result.slot};
    assign o_m_axis_tuser = result.kind;
    assign o_m_axis_tlast = result.last;

endmodule

`default_nettype wire

// ----- sv/stt_front.sv -----
`default_nettype none

module stt_front #(
    parameter int NUM_TIMERS = 32
) (
    input  wire logic          i_valid,
    input  wire logic [2:0]    i_action,
    input  wire logic [4:0]    i_index,
    input  wire logic [31:0]   i_timeout,
    input  wire logic [3:0]    i_queue,
    input  wire logic [7:0]    i_payload,
    input  wire logic          i_q_full,
    output logic               o_ready,
    output logic               o_push,
    output stt_pkg::t_cmd      o_cmd
);
    import stt_pkg::*;

    logic in_range;
    logic keep;

    assign in_range = {27'd0, i_index} < 32'(NUM_TIMERS);
    assign o_ready  = !i_q_full;

    always_comb begin
        unique case (i_action)
            OP_TICK, OP_ALLOC: begin
                keep = 1'b1;
            end
            OP_FREE, OP_INIT, OP_START: begin
                keep = in_range;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Unknown actions and out-of-range entries are consumed without a queue slot.
    assign o_push        = i_valid && !i_q_full && keep;
    assign o_cmd.op      = t_op'(i_action);
    assign o_cmd.idx     = i_index;
    assign o_cmd.timeout = i_timeout;
    assign o_cmd.queue   = i_queue;
    assign o_cmd.payload = i_payload;

endmodule

`default_nettype wire

// ----- sv/stt_queue.sv -----
`default_nettype none

module stt_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire stt_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output stt_pkg::t_cmd      o_cmd
);
    import stt_pkg::*;

    t_cmd            r_mem [QueueDepth];
    logic [PtrW-1:0] r_wp;
    logic [PtrW-1:0] r_rp;
    logic [PtrW:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = r_cnt == (PtrW + 1)'(QueueDepth);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/stt_back.sv -----
`default_nettype none

module stt_back #(
    parameter int NUM_TIMERS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire stt_pkg::t_cmd i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output stt_pkg::t_result   o_result
);
    import stt_pkg::*;

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IW-1:0] LastIdx = IW'(NUM_TIMERS - 1);

    t_state          r_state, n_state;
    t_status         r_status [NUM_TIMERS];
    logic [31:0]     r_rem    [NUM_TIMERS];
    logic [11:0]     r_qp     [NUM_TIMERS];
    logic [31:0]     r_rem_q;
    logic [11:0]     r_qp_q;
    logic [IW-1:0]   r_idx, n_idx;
    logic            r_iss, n_iss;
    logic            r_pv, n_pv;
    logic [IW-1:0]   r_pidx, n_pidx;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [31:0]     r_ticks, n_ticks;
    t_result         r_pend, n_pend;
    logic            r_pend_v, n_pend_v;
    t_result         r_out, n_out;
    logic            r_out_v, n_out_v;

    logic [IW-1:0]   cmd_idx;
    logic            can_load;
    logic [31:0]     rem_dec;
    logic            proc_run;
    logic            proc_exp;
    logic            report;
    logic            adv;
    logic            rd_en;
    logic            rem_we;
    logic [IW-1:0]   rem_wa;
    logic [31:0]     rem_wd;
    logic            qp_we;
    logic            st_we;
    logic [IW-1:0]   st_wa;
    t_status         st_wd;

    assign cmd_idx  = IW'(i_cmd.idx);
    assign can_load = !r_out_v || i_ready;
    assign rem_dec  = r_rem_q - 32'd1;
    assign proc_run = r_pv && (r_status[r_pidx] == ST_RUNNING);
    assign proc_exp = proc_run && (rem_dec == 32'd0);
    assign report   = proc_exp && (r_cnt < CntW'(MaxResults));
    assign adv      = !(report && r_pend_v && !can_load);

    assign o_valid  = r_out_v;
    assign o_result = r_out;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_iss    = r_iss;
        n_pv     = r_pv;
        n_pidx   = r_pidx;
        n_cnt    = r_cnt;
        n_ticks  = r_ticks;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_out    = r_out;
        n_out_v  = r_out_v && !i_ready;
        o_pop    = 1'b0;
        rd_en    = 1'b0;
        rem_we   = 1'b0;
        rem_wa   = cmd_idx;
        rem_wd   = i_cmd.timeout;
        qp_we    = 1'b0;
        st_we    = 1'b0;
        st_wa    = cmd_idx;
        st_wd    = ST_UNUSED;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_TICK: begin
                            n_ticks = r_ticks + 32'd1;
                            n_idx   = '0;
                            n_iss   = 1'b1;
                            n_pv    = 1'b0;
                            n_cnt   = '0;
                            n_state = S_TICK;
                        end
                        OP_ALLOC: begin
                            n_idx   = '0;
                            n_state = S_ALLOC;
                        end
                        OP_FREE: begin
                            st_we = 1'b1;
                            st_wd = ST_UNUSED;
                        end
                        OP_INIT: begin
                            qp_we = 1'b1;
                        end
                        OP_START: begin
                            rem_we = 1'b1;
                            st_we  = 1'b1;
                            st_wd  = ST_RUNNING;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                st_wa = r_idx;
                if (r_status[r_idx] == ST_UNUSED) begin
                    st_we    = 1'b1;
                    st_wd    = ST_ALLOC;
                    n_pend   = '{kind: KindAlloc, slot: 5'(r_idx), ok: 1'b1, queue: 4'd0,
                                 payload: 8'd0, ticks: 32'd0, last: 1'b1};
                    n_pend_v = 1'b1;
                    n_state  = S_FLUSH;
                end else if (r_idx == LastIdx) begin
                    n_pend   = '{kind: KindAlloc, slot: 5'd0, ok: 1'b0, queue: 4'd0,
                                 payload: 8'd0, ticks: 32'd0, last: 1'b1};
                    n_pend_v = 1'b1;
                    n_state  = S_FLUSH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_TICK: begin
                if (adv) begin
                    rd_en  = r_iss;
                    n_pv   = r_iss;
                    n_pidx = r_idx;
                    if (r_iss) begin
                        if (r_idx == LastIdx) begin
                            n_iss = 1'b0;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    if (proc_run) begin
                        rem_we = 1'b1;
                        rem_wa = r_pidx;
                        rem_wd = rem_dec;
                    end
                    if (proc_exp) begin
                        st_we = 1'b1;
                        st_wa = r_pidx;
                        st_wd = ST_ALLOC;
                    end
                    // The newest event waits in the pending register until it is known
                    // whether a later one follows.
                    if (report) begin
                        if (r_pend_v) begin
                            n_out   = r_pend;
                            n_out_v = 1'b1;
                        end
                        n_pend   = '{kind: KindExpire, slot: 5'(r_pidx), ok: 1'b0,
                                     queue: r_qp_q[11:8], payload: r_qp_q[7:0],
                                     ticks: r_ticks, last: 1'b0};
                        n_pend_v = 1'b1;
                        n_cnt    = r_cnt + 1'b1;
                    end
                    if (!r_iss && !r_pv) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (can_load) begin
                    n_out      = r_pend;
                    n_out.last = 1'b1;
                    n_out_v    = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rem_we) begin
            r_rem[rem_wa] <= rem_wd;
        end
        if (rd_en) begin
            r_rem_q <= r_rem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (qp_we) begin
            r_qp[cmd_idx] <= {i_cmd.queue, i_cmd.payload};
        end
        if (rd_en) begin
            r_qp_q <= r_qp[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_status[i] <= ST_UNUSED;
            end
        end else if (st_we) begin
            r_status[st_wa] <= st_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_iss    <= 1'b0;
            r_pv     <= 1'b0;
            r_cnt    <= '0;
            r_ticks  <= 32'd0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_iss    <= n_iss;
            r_pv     <= n_pv;
            r_cnt    <= n_cnt;
            r_ticks  <= n_ticks;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_pidx <= n_pidx;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(MaxResults))
        else $error("expiry report count exceeds its limit");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("pending result left behind when returning to idle");

    a_alloc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_out.kind == KindAlloc)) |-> r_out.last)
        else $error("allocation reply without the last marker");

    a_pipe_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv || r_iss) |-> (r_state == S_TICK))
        else $error("sweep pipeline active outside a tick");

endmodule

`default_nettype wire
